FILE: sv/gsa_pkg.sv
`default_nettype none
package gsa_pkg;

   // field widths of the stream payloads
   localparam int INDEX_W  = 10;
   localparam int GENF_W   = 16;
   localparam int SERIAL_W = 64;
   localparam int COUNT_W  = 11;
   localparam int OP_W     = 2;

   // request tdata: valid, texture, index, generation, serial (92 bits, padded to 96)
   localparam int REQ_DATA_W = 96;
   // response tdata: ok, index, generation, reclaimed (38 bits, padded to 40)
   localparam int RSP_DATA_W = 40;

   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_CHECK   = 2'd1;
   localparam logic [OP_W-1:0] OP_RETIRE  = 2'd2;
   localparam logic [OP_W-1:0] OP_COLLECT = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic latch;        // take request beat
      logic alloc_pop;    // read top of free stack, pop
      logic alloc_stk;    // slot from stack data, read its record
      logic alloc_fresh;  // slot from high-water mark, read its record
      logic alloc_commit; // write record, set result
      logic chk_rd;       // read record of handle index
      logic chk_eval;     // validate handle, retire if asked
      logic scan_start;   // clear scan index
      logic scan_rd;      // read record and serial of scan index
      logic scan_eval;    // free slot if retired and complete
      logic load_out;     // move result to response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            free_empty;
      logic            hw_full;
      logic            scan_done;
      logic            out_free;
   } status_type;

endpackage
`default_nettype wire

FILE: sv/gsa_ram.sv
`default_nettype none
module gsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: sv/gsa_ctrl.sv
`default_nettype none
module gsa_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire gsa_pkg::status_type status,
   output gsa_pkg::cmd_type         cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DISPATCH  = 3'd1;
   localparam logic [2:0] S_ALLOC_STK = 3'd2;
   localparam logic [2:0] S_ALLOC_REC = 3'd3;
   localparam logic [2:0] S_CHK_EV    = 3'd4;
   localparam logic [2:0] S_SCAN_RD   = 3'd5;
   localparam logic [2:0] S_SCAN_EV   = 3'd6;
   localparam logic [2:0] S_DONE      = 3'd7;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.op)
               gsa_pkg::OP_ALLOC: begin
                  if (!status.free_empty) begin
                     cmd.alloc_pop = 1'b1;
                     state_in      = S_ALLOC_STK;
                  end else if (!status.hw_full) begin
                     cmd.alloc_fresh = 1'b1;
                     state_in        = S_ALLOC_REC;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               gsa_pkg::OP_CHECK, gsa_pkg::OP_RETIRE: begin
                  cmd.chk_rd = 1'b1;
                  state_in   = S_CHK_EV;
               end
               default: begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN_RD;
               end
            endcase
         end
         S_ALLOC_STK: begin
            cmd.alloc_stk = 1'b1;
            state_in      = S_ALLOC_REC;
         end
         S_ALLOC_REC: begin
            cmd.alloc_commit = 1'b1;
            state_in         = S_DONE;
         end
         S_CHK_EV: begin
            cmd.chk_eval = 1'b1;
            state_in     = S_DONE;
         end
         S_SCAN_RD: begin
            if (status.scan_done) begin
               state_in = S_DONE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            cmd.scan_eval = 1'b1;
            state_in      = S_SCAN_RD;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/gsa_dpath.sv
`default_nettype none
module gsa_dpath #(
   parameter int SLOT_COUNT      = 1024,
   parameter int GENERATION_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire gsa_pkg::cmd_type                  cmd,
   output gsa_pkg::status_type                    status,
   input  wire logic [gsa_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic [gsa_pkg::OP_W-1:0]          req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [gsa_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam int GEN_W = GENERATION_BITS;
   localparam int REC_W = GEN_W + 2;
   localparam int CMP_W = (CNT_W > gsa_pkg::INDEX_W) ? CNT_W : gsa_pkg::INDEX_W;
   localparam int CG_W  = (GEN_W > gsa_pkg::GENF_W) ? GEN_W : gsa_pkg::GENF_W;

   // latched request
   logic [gsa_pkg::OP_W-1:0]     op_ff;
   logic                         hvalid_ff, htex_ff;
   logic [gsa_pkg::INDEX_W-1:0]  idx_ff;
   logic [gsa_pkg::GENF_W-1:0]   gen_ff;
   logic [gsa_pkg::SERIAL_W-1:0] serial_ff;

   // allocator state
   logic [CNT_W-1:0] free_count_ff, high_water_ff, scan_ff, count_ff;
   logic [IDX_W-1:0] slot_ff;
   logic             fresh_ff;

   // pending result and response register
   logic                         res_ok_ff;
   logic [gsa_pkg::INDEX_W-1:0]  res_idx_ff;
   logic [gsa_pkg::GENF_W-1:0]   res_gen_ff;
   logic                         rsp_valid_ff;
   logic [gsa_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // memory ports
   logic                         rec_we, rec_re, stk_we, ser_we;
   logic [IDX_W-1:0]             rec_wa, rec_ra, stk_wa, stk_ra;
   logic [REC_W-1:0]             rec_wd, rec_rd;
   logic [IDX_W-1:0]             stk_rd;
   logic [gsa_pkg::SERIAL_W-1:0] ser_rd;

   logic             rec_occ, rec_ret;
   logic [GEN_W-1:0] rec_gen;
   logic             handle_ok, scan_hit, retire_hit;

   assign rec_occ = rec_rd[GEN_W+1];
   assign rec_ret = rec_rd[GEN_W];
   assign rec_gen = rec_rd[GEN_W-1:0];

   // handle validation against the record just read
   assign handle_ok = hvalid_ff && htex_ff
                   && (CMP_W'(idx_ff) < CMP_W'(high_water_ff))
                   && (CMP_W'(idx_ff) < CMP_W'(SLOT_COUNT))
                   && rec_occ && !rec_ret
                   && (CG_W'(rec_gen) == CG_W'(gen_ff));
   assign retire_hit = cmd.chk_eval && (op_ff == gsa_pkg::OP_RETIRE) && handle_ok;
   assign scan_hit   = cmd.scan_eval && rec_occ && rec_ret && (ser_rd <= serial_ff);

   // record read address
   always_comb begin
      rec_re = cmd.chk_rd | cmd.alloc_stk | cmd.alloc_fresh | cmd.scan_rd;
      rec_ra = scan_ff[IDX_W-1:0];
      if (cmd.chk_rd) begin
         rec_ra = IDX_W'(idx_ff);
      end else if (cmd.alloc_stk) begin
         rec_ra = stk_rd;
      end else if (cmd.alloc_fresh) begin
         rec_ra = high_water_ff[IDX_W-1:0];
      end
   end

   // record write: allocate, retire or free
   always_comb begin
      rec_we = cmd.alloc_commit | retire_hit | scan_hit;
      rec_wa = slot_ff;
      rec_wd = {2'b10, (fresh_ff ? GEN_W'(0) : rec_gen)};
      if (retire_hit) begin
         rec_wa = IDX_W'(idx_ff);
         rec_wd = {2'b11, rec_gen + GEN_W'(1)};
      end else if (scan_hit) begin
         rec_wa = scan_ff[IDX_W-1:0];
         rec_wd = {2'b00, rec_gen};
      end
   end

   assign ser_we = retire_hit;
   assign stk_we = scan_hit && (free_count_ff < CNT_W'(SLOT_COUNT));
   assign stk_wa = free_count_ff[IDX_W-1:0];
   assign stk_ra = IDX_W'(free_count_ff - CNT_W'(1));

   gsa_ram #(.WIDTH(REC_W), .DEPTH(SLOT_COUNT)) u_rec (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_wa),
      .wr_data (rec_wd),
      .rd_en   (rec_re),
      .rd_addr (rec_ra),
      .rd_data (rec_rd)
   );

   gsa_ram #(.WIDTH(gsa_pkg::SERIAL_W), .DEPTH(SLOT_COUNT)) u_ser (
      .clock   (clock),
      .wr_en   (ser_we),
      .wr_addr (IDX_W'(idx_ff)),
      .wr_data (serial_ff),
      .rd_en   (cmd.scan_rd),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (ser_rd)
   );

   gsa_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_stk (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wa),
      .wr_data (scan_ff[IDX_W-1:0]),
      .rd_en   (cmd.alloc_pop),
      .rd_addr (stk_ra),
      .rd_data (stk_rd)
   );

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff     <= req_tuser;
         hvalid_ff <= req_tdata[0];
         htex_ff   <= req_tdata[1];
         idx_ff    <= req_tdata[11:2];
         gen_ff    <= req_tdata[27:12];
         serial_ff <= req_tdata[91:28];
      end
   end

   // counters and control
   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= '0;
         high_water_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.alloc_pop) begin
            free_count_ff <= free_count_ff - CNT_W'(1);
         end else if (stk_we) begin
            free_count_ff <= free_count_ff + CNT_W'(1);
         end
         if (cmd.alloc_fresh) begin
            high_water_ff <= high_water_ff + CNT_W'(1);
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // slot, scan and result payload
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         res_ok_ff  <= 1'b0;
         res_idx_ff <= '0;
         res_gen_ff <= '0;
         count_ff   <= '0;
      end
      if (cmd.alloc_stk) begin
         slot_ff  <= stk_rd;
         fresh_ff <= 1'b0;
      end
      if (cmd.alloc_fresh) begin
         slot_ff  <= high_water_ff[IDX_W-1:0];
         fresh_ff <= 1'b1;
      end
      if (cmd.alloc_commit) begin
         res_ok_ff  <= 1'b1;
         res_idx_ff <= gsa_pkg::INDEX_W'(slot_ff);
         res_gen_ff <= gsa_pkg::GENF_W'(fresh_ff ? GEN_W'(0) : rec_gen);
      end
      if (cmd.chk_eval) begin
         res_ok_ff <= handle_ok;
      end
      if (cmd.scan_start) begin
         scan_ff <= '0;
      end
      if (cmd.scan_eval) begin
         scan_ff <= scan_ff + CNT_W'(1);
         if (scan_hit) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
      if (cmd.load_out) begin
         rsp_data_ff <= {2'b00, gsa_pkg::COUNT_W'(count_ff), res_gen_ff, res_idx_ff, res_ok_ff};
      end
   end

   assign status.op         = op_ff;
   assign status.free_empty = (free_count_ff == '0);
   assign status.hw_full    = (high_water_ff >= CNT_W'(SLOT_COUNT));
   assign status.scan_done  = (scan_ff >= high_water_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // free slots are always a subset of the used ones
   a_free_le_hw: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= high_water_ff) else $error("free count above high-water mark");

   a_hw_range: assert property (@(posedge clock) disable iff (reset)
      high_water_ff <= CNT_W'(SLOT_COUNT)) else $error("high-water mark out of range");

   // a freed slot is pushed onto the stack
   a_push: assert property (@(posedge clock) disable iff (reset)
      scan_hit |=> free_count_ff == $past(free_count_ff) + CNT_W'(1))
      else $error("collected slot not pushed");

   // a pop is only issued with a non-empty stack
   a_pop: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_pop |-> free_count_ff != '0) else $error("pop from empty stack");

endmodule
`default_nettype wire

FILE: sv/generational_slot_allocator_core.sv
`default_nettype none
// channel   dir  handshake             payload
// req       in   req_tvalid/tready     tuser opcode; tdata valid, texture, index, gen, serial
// rsp       out  rsp_tvalid/tready     tdata ok, index, generation, reclaimed
//
// Allocate: pops the free stack and reads that slot's record, or takes the high-water
// mark and reads its record, then commits; on a full heap it goes straight to done.
// Check and retire: record read, then evaluate and write back.
// Collect: each slot below the high-water mark takes a record/serial
// read and an evaluate step through the slot memory ports.
// The next beat is taken in the cycle after the result is loaded; a result waits in
// the response register meanwhile, and a full register holds the last step.
// Synchronous reset clears the free count, high-water mark and response valid; slot memories need no clearing pass,
// since entries at or above the high-water mark read as empty.
module generational_slot_allocator_core #(
   parameter int SLOT_COUNT      = 1024,
   parameter int GENERATION_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [0] handle_valid, [1] handle_is_texture, [11:2] slot_index,
   // [27:12] slot_generation, [91:28] serial
   input  wire logic [gsa_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] opcode
   input  wire logic [gsa_pkg::OP_W-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [0] ok, [10:1] out_index, [26:11] out_generation, [37:27] reclaimed
   output logic      [gsa_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   gsa_pkg::cmd_type    cmd;
   gsa_pkg::status_type status;

   gsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gsa_dpath #(
      .SLOT_COUNT      (SLOT_COUNT),
      .GENERATION_BITS (GENERATION_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`default_nettype none
module tb_top;

   localparam int NSLOT     = 1024;
   localparam int WDOG_MAX  = 20000;

   typedef struct packed {
      logic        ok;
      logic [9:0]  index;
      logic [15:0] gen;
      logic [10:0] reclaimed;
   } result_type;

   typedef struct {
      logic [1:0]  op;
      logic        hvalid;
      logic        htex;
      logic [9:0]  index;
      logic [15:0] gen;
      logic [63:0] serial;
      bit          typed;
      result_type  want;
   } stim_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [gsa_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [gsa_pkg::OP_W-1:0]       req_tuser = gsa_pkg::OP_ALLOC;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [gsa_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // shadow copy of the allocator state
   bit          occ_bits [NSLOT];
   bit          ret_bits [NSLOT];
   logic [15:0] slot_gen [NSLOT];
   logic [63:0] slot_serial [NSLOT];
   logic [9:0]  free_lifo [NSLOT];
   int          free_depth;
   int          high_mark;

   result_type  pending_results [$];
   int          errors = 0;
   int          snd_pct = 0;
   int          rcv_pct = 0;
   int          hold_len = 0;
   int          quiet_cycles = 0;
   logic [63:0] serial_now;

   generational_slot_allocator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // handle check: valid mark, texture kind, in range, live, current generation
   function automatic bit handle_live(logic hv, logic ht, logic [9:0] idx, logic [15:0] g);
      if (!hv || !ht) return 0;
      if (int'(idx) >= high_mark) return 0;
      if (!occ_bits[idx] || ret_bits[idx]) return 0;
      return slot_gen[idx] == g;
   endfunction

   // next result of the allocator; updates the shadow state
   function automatic result_type slot_step(logic [1:0] op, logic hv, logic ht,
                                            logic [9:0] idx, logic [15:0] g,
                                            logic [63:0] ser);
      result_type r;
      int         slot;
      int         n;
      r = '0;
      slot = -1;
      n = 0;
      case (op)
         gsa_pkg::OP_ALLOC: begin
            if (free_depth > 0) begin
               free_depth--;
               slot = free_lifo[free_depth];
            end else if (high_mark < NSLOT) begin
               slot = high_mark;
               high_mark++;
            end
            if (slot >= 0) begin
               occ_bits[slot] = 1;
               ret_bits[slot] = 0;
               r.ok = 1'b1;
               r.index = slot[9:0];
               r.gen = slot_gen[slot];
            end
         end
         gsa_pkg::OP_CHECK: r.ok = handle_live(hv, ht, idx, g);
         gsa_pkg::OP_RETIRE: begin
            if (handle_live(hv, ht, idx, g)) begin
               ret_bits[idx] = 1;
               slot_serial[idx] = ser;
               slot_gen[idx] = slot_gen[idx] + 16'd1;
               r.ok = 1'b1;
            end
         end
         default: begin
            for (int i = 0; i < high_mark; i++) begin
               if (occ_bits[i] && ret_bits[i] && slot_serial[i] <= ser) begin
                  occ_bits[i] = 0;
                  ret_bits[i] = 0;
                  free_lifo[free_depth] = i[9:0];
                  free_depth++;
                  n++;
               end
            end
            r.reclaimed = n[10:0];
         end
      endcase
      return r;
   endfunction

   // offer one beat, wait for acceptance, queue the expected result
   task automatic send_beat(logic [1:0] op, logic hv, logic ht, logic [9:0] idx,
                            logic [15:0] g, logic [63:0] ser, bit typed, result_type want);
      result_type r;
      if ($urandom_range(99) < snd_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, ser, g, idx, ht, hv};
      do @(posedge clock); while (!req_tready);
      r = slot_step(op, hv, ht, idx, g, ser);
      if (typed) r = want;
      pending_results = {pending_results, r};
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // one random beat, mostly well-formed handles of slots below the high mark
   task automatic random_beat();
      int          pick;
      logic [9:0]  idx;
      logic [15:0] g;
      logic [63:0] ser;
      logic        hv;
      logic        ht;
      pick = $urandom_range(99);
      hv = 1'b1;
      ht = 1'b1;
      idx = (high_mark > 0) ? 10'($urandom_range(high_mark - 1)) : 10'd0;
      g = slot_gen[idx];
      ser = serial_now;
      if ($urandom_range(99) < 12) begin
         case ($urandom_range(3))
            0: hv = 1'b0;
            1: ht = 1'b0;
            2: g = 16'($urandom);
            default: idx = 10'($urandom);
         endcase
      end
      if (pick < 30) begin
         send_beat(gsa_pkg::OP_ALLOC, hv, ht, idx, g, ser, 0, '0);
      end else if (pick < 55) begin
         send_beat(gsa_pkg::OP_CHECK, hv, ht, idx, g, ser, 0, '0);
      end else if (pick < 80) begin
         serial_now = serial_now + 64'($urandom_range(3));
         send_beat(gsa_pkg::OP_RETIRE, hv, ht, idx, g,
                   serial_now + 64'($urandom_range(15)), 0, '0);
      end else if (pick < 92) begin
         send_beat(gsa_pkg::OP_COLLECT, hv, ht, idx, g,
                   serial_now - 64'($urandom_range(10)), 0, '0);
      end else begin
         send_beat(2'($urandom), 1'($urandom), 1'($urandom), 10'($urandom), 16'($urandom),
                   {$urandom, $urandom}, 0, '0);
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_len > 0) begin
         hold_len = hold_len - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok        = rsp_tdata[0];
         got.index     = rsp_tdata[10:1];
         got.gen       = rsp_tdata[26:11];
         got.reclaimed = rsp_tdata[37:27];
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (got.ok !== want.ok || got.index !== want.index || got.gen !== want.gen ||
                got.reclaimed !== want.reclaimed) begin
               $display("%0t: expected ok %0d idx %0d gen %0d recl %0d,",
                        $time, want.ok, want.index, want.gen, want.reclaimed,
                        " got ok %0d idx %0d gen %0d recl %0d",
                        got.ok, got.index, got.gen, got.reclaimed);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any beat moving
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
         $display("generational_slot_allocator_core: mismatch");
         $finish;
      end
   end

   localparam logic [63:0] SMAX = 64'hFFFF_FFFF_FFFF_FFFF;

   stim_row_type directed [] = '{
      '{gsa_pkg::OP_COLLECT, 1, 1, 10'd0,    16'd0,    64'd0,    1, '{0, 0, 0, 0}},
      '{gsa_pkg::OP_CHECK,   1, 1, 10'd0,    16'd0,    64'd0,    1, '{0, 0, 0, 0}},
      '{gsa_pkg::OP_ALLOC,   0, 0, 10'd0,    16'd0,    64'd0,    1, '{1, 0, 0, 0}},
      '{gsa_pkg::OP_ALLOC,   0, 0, 10'd1023, 16'hFFFF, SMAX,     1, '{1, 1, 0, 0}},
      '{gsa_pkg::OP_CHECK,   1, 1, 10'd0,    16'd0,    64'd0,    1, '{1, 0, 0, 0}},
      '{gsa_pkg::OP_CHECK,   0, 1, 10'd0,    16'd0,    64'd0,    1, '{0, 0, 0, 0}},
      '{gsa_pkg::OP_CHECK,   1, 0, 10'd0,    16'd0,    64'd0,    1, '{0, 0, 0, 0}},
      '{gsa_pkg::OP_CHECK,   1, 1, 10'd0,    16'hFFFF, 64'd0,    1, '{0, 0, 0, 0}},
      '{gsa_pkg::OP_CHECK,   1, 1, 10'd1023, 16'd0,    64'd0,    1, '{0, 0, 0, 0}},
      '{gsa_pkg::OP_RETIRE,  1, 1, 10'd0,    16'd0,    SMAX,     1, '{1, 0, 0, 0}},
      '{gsa_pkg::OP_CHECK,   1, 1, 10'd0,    16'd1,    64'd0,    1, '{0, 0, 0, 0}},
      '{gsa_pkg::OP_RETIRE,  1, 1, 10'd0,    16'd1,    64'd5,    1, '{0, 0, 0, 0}},
      '{gsa_pkg::OP_COLLECT, 0, 0, 10'd0,    16'd0,    SMAX - 1, 1, '{0, 0, 0, 0}},
      '{gsa_pkg::OP_COLLECT, 0, 0, 10'd0,    16'd0,    SMAX,     1, '{0, 0, 0, 1}},
      '{gsa_pkg::OP_ALLOC,   1, 1, 10'd0,    16'd0,    64'd0,    1, '{1, 0, 1, 0}},
      '{gsa_pkg::OP_RETIRE,  1, 1, 10'd1,    16'd0,    64'd0,    1, '{1, 0, 0, 0}},
      '{gsa_pkg::OP_RETIRE,  1, 1, 10'd0,    16'd1,    64'd7,    0, '{0, 0, 0, 0}},
      '{gsa_pkg::OP_COLLECT, 1, 1, 10'd1023, 16'hFFFF, 64'd6,    0, '{0, 0, 0, 0}},
      '{gsa_pkg::OP_ALLOC,   0, 0, 10'd0,    16'd0,    64'd0,    0, '{0, 0, 0, 0}},
      '{gsa_pkg::OP_ALLOC,   0, 0, 10'd0,    16'd0,    64'd0,    0, '{0, 0, 0, 0}},
      '{gsa_pkg::OP_COLLECT, 0, 0, 10'd0,    16'd0,    64'd7,    0, '{0, 0, 0, 0}},
      '{gsa_pkg::OP_ALLOC,   0, 0, 10'd0,    16'd0,    64'd0,    0, '{0, 0, 0, 0}}
   };

   initial begin
      int wait_cycles;
      free_depth = 0;
      high_mark = 0;
      for (int i = 0; i < NSLOT; i++) begin
         occ_bits[i] = 0;
         ret_bits[i] = 0;
         slot_gen[i] = '0;
      end
      serial_now = {1'b0, 31'($urandom), 32'($urandom)};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed[k])
         send_beat(directed[k].op, directed[k].hvalid, directed[k].htex, directed[k].index,
                   directed[k].gen, directed[k].serial, directed[k].typed, directed[k].want);

      // cycle slot 0 through several generations
      drain();
      for (int n = 0; n < 10; n++) begin
         send_beat(gsa_pkg::OP_RETIRE, 1, 1, 10'd0, slot_gen[0], 64'd0, 0, '0);
         send_beat(gsa_pkg::OP_COLLECT, 0, 0, 10'd0, 16'd0, 64'd0, 0, '0);
         send_beat(gsa_pkg::OP_ALLOC, 0, 0, 10'd0, 16'd0, 64'd0, 0, '0);
      end
      send_beat(gsa_pkg::OP_CHECK, 1, 1, 10'd0, slot_gen[0], 64'd0, 0, '0);

      // random phases under the idling patterns
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin snd_pct = 0;  rcv_pct = 0;  end
            1: begin snd_pct = 59; rcv_pct = 0;  end
            2: begin snd_pct = 0;  rcv_pct = 59; end
            default: begin snd_pct = 33; rcv_pct = 33; end
         endcase
         if (ph == 2) hold_len = 400;
         for (int n = 0; n < 145; n++) random_beat();
         if (ph == 1) drain();
      end

      // try to retire slots 1023 and 0, then collect and allocate
      snd_pct = 0;
      rcv_pct = 0;
      send_beat(gsa_pkg::OP_CHECK, 1, 1, 10'd1023, slot_gen[1023], 64'd0, 0, '0);
      send_beat(gsa_pkg::OP_RETIRE, 1, 1, 10'd1023, slot_gen[1023], serial_now, 0, '0);
      send_beat(gsa_pkg::OP_RETIRE, 1, 1, 10'd0, slot_gen[0], serial_now, 0, '0);
      send_beat(gsa_pkg::OP_COLLECT, 0, 0, 10'd0, 16'd0, SMAX, 0, '0);
      repeat (3) send_beat(gsa_pkg::OP_ALLOC, 0, 0, 10'd0, 16'd0, 64'd0, 0, '0);

      // wait for the tail of results, then idle before the verdict
      drain();
      wait_cycles = 0;
      while (wait_cycles < 50) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (errors == 0 && pending_results.size() == 0)
         $display("generational_slot_allocator_core: match");
      else
         $display("generational_slot_allocator_core: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
